// ----- src/scc_pkg.sv -----
// shared constants and types for the strongly connected components block
package scc_pkg;
    localparam int MAX_VERTICES = 16;
    localparam int MAX_EDGES    = 64;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int CW = EW + 1;
    localparam int NW = VW + 1;
    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_RUN  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic store_edge;
        logic start_run;
        logic next_root;
        logic enter_root;
        logic cursor_read;
        logic edge_eval;
        logic frame_done;
        logic pop_one;
        logic frame_pop;
        logic finish;
        logic load_out;
    } scc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic root_done;
        logic root_visited;
        logic cursor_zero;
        logic descend;
        logic is_root;
        logic pop_last;
        logic frames_empty;
    } scc_stat_t;
endpackage

// ----- src/scc_datapath.sv -----
// edge memory, marks, stacks and output register of the search
module scc_datapath import scc_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [4:0]      cfg_wdata,
    input  logic [VW-1:0]   edge_from,
    input  logic [VW-1:0]   edge_to,
    input  scc_cmd_t        cmd,
    output scc_stat_t       stat,
    output logic [VW-1:0]   pop_vertex,
    output logic            pop_is_end,
    output logic            drop_out
);
    logic [4:0]    nv_reg;
    logic [NW-1:0] n_lim;
    logic [VW-1:0] esrc [MAX_EDGES];
    logic [VW-1:0] edst [MAX_EDGES];
    logic [CW-1:0] ecount_reg;
    logic          drop_reg, drop_run_reg;
    logic [MAX_VERTICES-1:0] visited_reg, onstk_reg;
    logic [VW-1:0] order_of [MAX_VERTICES];
    logic [VW-1:0] low_of [MAX_VERTICES];
    logic [VW-1:0] cstack [MAX_VERTICES];
    logic [VW-1:0] fvert [MAX_VERTICES];
    logic [CW-1:0] fcur [MAX_VERTICES];
    logic [NW-1:0] ctop_reg, ftop_reg;
    logic [VW:0]   order_reg;
    logic [NW-1:0] root_reg;
    logic [VW-1:0] es_reg, ed_reg;
    logic [VW-1:0] pend_vertex_reg;
    logic          pend_end_reg;
    logic [VW-1:0] v_top, w_new, x_pop;
    logic [VW-1:0] fidx, cidx;
    logic          edge_ok;

    // saturated vertex count
    assign n_lim = (nv_reg > 5'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(nv_reg);
    assign fidx  = VW'(ftop_reg - 1'b1);
    assign cidx  = VW'(ctop_reg - 1'b1);
    assign v_top = fvert[fidx];
    assign x_pop = cstack[cidx];
    assign w_new = ed_reg;
    assign edge_ok = (es_reg == v_top) && ({1'b0, ed_reg} < n_lim);

    // status toward the controller
    assign stat.root_done    = (root_reg >= n_lim);
    assign stat.root_visited = visited_reg[root_reg[VW-1:0]];
    assign stat.cursor_zero  = (fcur[fidx] == '0);
    assign stat.descend      = edge_ok && !visited_reg[w_new];
    assign stat.is_root      = (order_of[v_top] == low_of[v_top]);
    assign stat.pop_last     = (x_pop == v_top) || (ctop_reg <= NW'(1));
    assign stat.frames_empty = (ftop_reg == NW'(1));

    // edge memory write and cursor read
    always_ff @(posedge aclk) begin
        if (cmd.store_edge && ecount_reg < CW'(MAX_EDGES)
            && {1'b0, edge_from} < n_lim && {1'b0, edge_to} < n_lim) begin
            esrc[ecount_reg[EW-1:0]] <= edge_from;
            edst[ecount_reg[EW-1:0]] <= edge_to;
        end
        if (cmd.cursor_read) begin
            es_reg <= esrc[EW'(fcur[fidx] - 1'b1)];
            ed_reg <= edst[EW'(fcur[fidx] - 1'b1)];
        end
    end

    // search state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_reg <= 5'(MAX_VERTICES);
            ecount_reg <= '0;
            drop_reg <= 1'b0;
            drop_run_reg <= 1'b0;
            visited_reg <= '0;
            onstk_reg <= '0;
            ctop_reg <= '0;
            ftop_reg <= '0;
            order_reg <= '0;
            root_reg <= '0;
        end else begin
            if (cfg_we) nv_reg <= cfg_wdata;
            if (cmd.store_edge) begin
                if (ecount_reg >= CW'(MAX_EDGES) || {1'b0, edge_from} >= n_lim
                    || {1'b0, edge_to} >= n_lim)
                    drop_reg <= 1'b1;
                else
                    ecount_reg <= ecount_reg + 1'b1;
            end
            if (cmd.start_run) begin
                drop_run_reg <= drop_reg;
                root_reg <= '0;
            end
            if (cmd.next_root) root_reg <= root_reg + 1'b1;
            if (cmd.enter_root || (cmd.edge_eval && stat.descend)) begin
                logic [VW-1:0] nv;
                nv = cmd.enter_root ? root_reg[VW-1:0] : w_new;
                visited_reg[nv] <= 1'b1;
                onstk_reg[nv] <= 1'b1;
                order_of[nv] <= order_reg[VW-1:0];
                low_of[nv] <= order_reg[VW-1:0];
                order_reg <= order_reg + 1'b1;
                cstack[ctop_reg[VW-1:0]] <= nv;
                ctop_reg <= ctop_reg + 1'b1;
                fvert[ftop_reg[VW-1:0]] <= nv;
                fcur[ftop_reg[VW-1:0]] <= ecount_reg;
                ftop_reg <= ftop_reg + 1'b1;
            end
            if (cmd.cursor_read) fcur[fidx] <= fcur[fidx] - 1'b1;
            if (cmd.edge_eval && edge_ok && visited_reg[w_new] && onstk_reg[w_new]
                && order_of[w_new] < low_of[v_top])
                low_of[v_top] <= order_of[w_new];
            // popped vertex waits here until the next pop or the end of the run tells whether it is last
            if (cmd.pop_one) begin
                onstk_reg[x_pop] <= 1'b0;
                ctop_reg <= ctop_reg - 1'b1;
                pend_vertex_reg <= x_pop;
                pend_end_reg <= (x_pop == v_top);
            end
            // pending vertex moves into the output register
            if (cmd.load_out) begin
                pop_vertex <= pend_vertex_reg;
                pop_is_end <= pend_end_reg;
            end
            if (cmd.frame_pop) begin
                ftop_reg <= ftop_reg - 1'b1;
                if (ftop_reg > NW'(1) && low_of[v_top] < low_of[fvert[VW'(ftop_reg - 2'd2)]])
                    low_of[fvert[VW'(ftop_reg - 2'd2)]] <= low_of[v_top];
            end
            if (cmd.finish) begin
                ecount_reg <= '0;
                drop_reg <= 1'b0;
                visited_reg <= '0;
                onstk_reg <= '0;
                ctop_reg <= '0;
                ftop_reg <= '0;
                order_reg <= '0;
            end
        end
    end

    assign drop_out = drop_run_reg;

    // roots enter with no frames, pops never hit an empty stack, finish clears edges and marks
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.enter_root |-> ftop_reg == '0) else $error("root entered with frames");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop_one |-> ctop_reg != '0) else $error("pop of empty stack");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> ecount_reg == '0 && visited_reg == '0) else $error("no clear");
endmodule

// ----- src/scc_ctrl.sv -----
// sequencer of the depth-first search and output handshake
module scc_ctrl import scc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      req_run,
    output logic      m_tvalid,
    input  logic      m_tready,
    output logic      m_last,
    output scc_cmd_t  cmd,
    input  scc_stat_t stat
);
    localparam logic [3:0] S_IDLE = 4'd0, S_ROOT = 4'd1, S_FRAME = 4'd2,
        S_EVAL = 4'd3, S_POP = 4'd4, S_HOLD = 4'd5, S_FPOP = 4'd6,
        S_DONE = 4'd7, S_FLUSH = 4'd8;
    logic [3:0] state_reg, state_next;
    logic       hold_valid_reg, hold_valid_next, hold_last_reg, hold_last_next;
    logic       pend_reg, pend_next;

    assign m_tvalid = hold_valid_reg;
    assign m_last   = hold_last_reg;
    assign s_tready = (state_reg == S_IDLE);

    // state transitions and commands
    always_comb begin
        cmd = '0;
        state_next = state_reg;
        hold_valid_next = hold_valid_reg && !m_tready;
        hold_last_next = hold_last_reg;
        pend_next = pend_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (req_run) begin
                        cmd.start_run = 1'b1;
                        pend_next = 1'b0;
                        state_next = S_ROOT;
                    end else cmd.store_edge = 1'b1;
                end
            end
            S_ROOT: begin
                if (stat.root_done) state_next = S_DONE;
                else if (stat.root_visited) cmd.next_root = 1'b1;
                else begin
                    cmd.enter_root = 1'b1;
                    cmd.next_root = 1'b1;
                    state_next = S_FRAME;
                end
            end
            S_FRAME: begin
                if (stat.cursor_zero) begin
                    state_next = stat.is_root ? S_POP : S_FPOP;
                end else begin
                    cmd.cursor_read = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.edge_eval = 1'b1;
                state_next = S_FRAME;
            end
            S_POP: begin
                // only pop when the output register can take the word
                if (!hold_valid_reg || m_tready) begin
                    if (pend_reg) begin
                        hold_valid_next = 1'b1;
                        hold_last_next = 1'b0;
                        cmd.load_out = 1'b1;
                    end
                    cmd.pop_one = 1'b1;
                    pend_next = 1'b1;
                    state_next = stat.pop_last ? S_FPOP : S_POP;
                end
            end
            S_FPOP: begin
                cmd.frame_pop = 1'b1;
                state_next = stat.frames_empty ? S_ROOT : S_FRAME;
            end
            S_DONE: begin
                if (!pend_reg) begin
                    cmd.finish = 1'b1;
                    state_next = S_FLUSH;
                end else if (!hold_valid_reg || m_tready) begin
                    hold_valid_next = 1'b1;
                    hold_last_next = 1'b1;
                    cmd.load_out = 1'b1;
                    pend_next = 1'b0;
                    cmd.finish = 1'b1;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!hold_valid_reg || m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            hold_valid_reg <= 1'b0;
            hold_last_reg <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            hold_valid_reg <= hold_valid_next;
            hold_last_reg <= hold_last_next;
            pend_reg <= pend_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_reg) else $error("pending word while idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop_one && hold_valid_reg) |-> m_tready) else $error("word overwritten");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH) |-> !pend_reg) else $error("word lost at end");
endmodule

// ----- src/strongly_connected_components.sv -----
// top level of the strongly connected components block
// channel  | dir | tdata (low bit up)          | tuser/tlast
// s_ edge  | in  | edge_from[3:0] edge_to[7:4]  | tuser = req_type
// m_ vert  | out | vertex[3:0]                 | tuser = component_end, edges_dropped; tlast
// edges are accepted while the block is idle; a run tries every stored edge for each vertex
// it visits, reading the edge memory one entry at a time in the search loop.
// a vertex word is held in the output register; the search stalls while it waits.
// reset is synchronous and leaves the block empty with 16 vertices.
module strongly_connected_components import scc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // edge_from, edge_to
    input  logic       s_tuser,   // req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // vertex, zero fill
    output logic [1:0] m_tuser,   // component_end, edges_dropped
    output logic       m_tlast
);
    scc_cmd_t  cmd;
    scc_stat_t stat;
    logic [VW-1:0] pop_vertex;
    logic pop_is_end, drop_out;

    scc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .req_run(s_tuser == REQ_RUN), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_last(m_tlast), .cmd(cmd), .stat(stat)
    );

    scc_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .edge_from(s_tdata[3:0]), .edge_to(s_tdata[7:4]), .cmd(cmd), .stat(stat),
        .pop_vertex(pop_vertex), .pop_is_end(pop_is_end), .drop_out(drop_out)
    );

    assign m_tdata = {4'b0, pop_vertex};
    assign m_tuser = {drop_out, pop_is_end};
endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the strongly connected components block
module tb_top;
    import scc_pkg::*;

    // output word as seen on the master side
    typedef struct packed {
        logic [3:0] vertex;
        logic       comp_end;
        logic       is_last;
        logic       dropped;
    } vert_word_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [4:0] cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // edge_from, edge_to
    logic       s_tuser;   // req_type
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // vertex, zero fill
    logic [1:0] m_tuser;   // component_end, edges_dropped
    logic       m_tlast;

    strongly_connected_components uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // predictor state
    logic [4:0] nv_reg;
    logic [3:0] e_src [MAX_EDGES];
    logic [3:0] e_dst [MAX_EDGES];
    int         e_cnt;
    logic       drop_seen;
    vert_word_t expected_words[$];

    int errors = 0;
    int mismatches = 0;
    int words_seen = 0;
    int runs_sent = 0;
    int edges_sent = 0;
    int idle_cycles = 0;

    // clock
    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // tarjan search on the shadow graph, queues the expected vertex words
    task automatic predict_components();
        int n, cnt, ft, st, oc, v, w, c, f, x;
        bit vis [16];
        bit ons [16];
        int ord [16];
        int low [16];
        int cstk [16];
        int fv [16];
        int fc [16];
        bit down;
        n = (nv_reg > 16) ? 16 : nv_reg;
        cnt = 0; ft = 0; st = 0; oc = 0;
        for (int i = 0; i < 16; i++) begin
            vis[i] = 0; ons[i] = 0;
        end
        for (int r = 0; r < n; r++) begin
            if (vis[r]) continue;
            vis[r] = 1; ons[r] = 1; ord[r] = oc; low[r] = oc; oc++;
            cstk[st] = r; st++;
            fv[ft] = r; fc[ft] = e_cnt; ft++;
            while (ft > 0) begin
                f = ft - 1;
                v = fv[f];
                down = 0;
                while (fc[f] > 0) begin
                    fc[f]--;
                    c = fc[f];
                    w = e_dst[c];
                    if (e_src[c] != v || w >= n) continue;
                    if (!vis[w]) begin
                        vis[w] = 1; ons[w] = 1; ord[w] = oc; low[w] = oc; oc++;
                        cstk[st] = w; st++;
                        fv[ft] = w; fc[ft] = e_cnt; ft++;
                        down = 1;
                        break;
                    end
                    if (ons[w] && ord[w] < low[v]) low[v] = ord[w];
                end
                if (down) continue;
                if (ord[v] == low[v]) begin
                    while (st > 0) begin
                        vert_word_t wd;
                        st--;
                        x = cstk[st];
                        ons[x] = 0;
                        wd.vertex = x[3:0];
                        wd.comp_end = (x == v);
                        wd.is_last = 0;
                        wd.dropped = drop_seen;
                        expected_words.push_back(wd);
                        cnt++;
                        if (x == v) break;
                    end
                end
                ft--;
                if (ft > 0 && low[v] < low[fv[ft-1]]) low[fv[ft-1]] = low[v];
            end
        end
        if (cnt > 0) expected_words[expected_words.size()-1].is_last = 1;
        e_cnt = 0;
        drop_seen = 0;
    endtask

    // send one request and update the shadow graph on acceptance
    task automatic send_req(input logic rt, input int src, input int dst);
        int n;
        logic [3:0] s4, d4;
        s4 = 4'(src);
        d4 = 4'(dst);
        s_tvalid <= 1;
        s_tuser <= rt;
        s_tdata <= {d4, s4};
        do @(posedge aclk); while (!s_tready);
        idle_cycles = 0;
        n = (nv_reg > 16) ? 16 : nv_reg;
        if (rt == REQ_RUN) begin
            predict_components();
            runs_sent++;
        end else begin
            edges_sent++;
            if (e_cnt >= MAX_EDGES || s4 >= n || d4 >= n) drop_seen = 1;
            else begin
                e_src[e_cnt] = s4; e_dst[e_cnt] = d4; e_cnt++;
            end
        end
        // bursts with random gaps
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 0;
        while (expected_words.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_nv(input logic [4:0] val);
        cfg_we <= 1;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        nv_reg = val;
    endtask

    task automatic random_graph(input int edges, input int hi);
        for (int i = 0; i < edges; i++)
            send_req(REQ_EDGE, $urandom_range(0, hi), $urandom_range(0, hi));
        send_req(REQ_RUN, $urandom_range(0, 15), $urandom_range(0, 15));
    endtask

    // directed cases: cycle, chain, self loop, drops, zero vertices
    task automatic test_directed();
        send_req(REQ_RUN, 15, 15);
        send_req(REQ_EDGE, 0, 1); send_req(REQ_EDGE, 1, 2); send_req(REQ_EDGE, 2, 0);
        send_req(REQ_EDGE, 15, 15); send_req(REQ_EDGE, 3, 15); send_req(REQ_EDGE, 15, 0);
        send_req(REQ_RUN, 0, 0);
        drain_and_settle();
        write_nv(5'd4);
        send_req(REQ_EDGE, 3, 2); send_req(REQ_EDGE, 4, 0); send_req(REQ_EDGE, 0, 15);
        send_req(REQ_EDGE, 2, 3); send_req(REQ_RUN, 0, 0);
        drain_and_settle();
        write_nv(5'd0);
        send_req(REQ_EDGE, 0, 0); send_req(REQ_RUN, 0, 0);
        drain_and_settle();
        write_nv(5'd1);
        send_req(REQ_EDGE, 0, 0); send_req(REQ_RUN, 0, 0);
        drain_and_settle();
    endtask

    // memory overflow and stale edges after lowering the vertex count
    task automatic test_overflow_and_stale();
        write_nv(5'd16);
        for (int i = 0; i < 66; i++) send_req(REQ_EDGE, i % 16, (i * 7 + 1) % 16);
        send_req(REQ_RUN, 0, 0);
        drain_and_settle();
        for (int i = 0; i < 10; i++)
            send_req(REQ_EDGE, $urandom_range(0, 15), $urandom_range(0, 15));
        drain_and_settle();
        write_nv(5'd6);
        send_req(REQ_RUN, 0, 0);
        drain_and_settle();
        write_nv(5'd31);
        random_graph(20, 15);
        drain_and_settle();
    endtask

    // random graphs over several vertex counts
    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 200) begin
            int ne, hi;
            write_nv(5'($urandom_range(1, 16)));
            for (int g = 0; g < 3; g++) begin
                ne = $urandom_range(0, 24);
                hi = ($urandom_range(0, 9) == 0) ? 15 : nv_reg - 1;
                random_graph(ne, hi);
                sent += ne + 1;
            end
            drain_and_settle();
        end
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 0;
        else m_tready <= ((words_seen / 8) % 3 == 2) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            vert_word_t got, exp;
            got.vertex = m_tdata[3:0];
            got.comp_end = m_tuser[0];
            got.dropped = m_tuser[1];
            got.is_last = m_tlast;
            words_seen++;
            idle_cycles = 0;
            if (expected_words.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", got);
            end else begin
                exp = expected_words.pop_front();
                if (got !== exp || m_tdata[7:4] !== 4'h0) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p (tdata %h)", exp, got, m_tdata);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            idle_cycles++;
            if (idle_cycles > 20000) begin
                $display("timeout waiting on handshake");
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 0;
        cfg_we = 0; cfg_wdata = 0;
        s_tvalid = 0; s_tdata = 0; s_tuser = 0;
        nv_reg = 16; e_cnt = 0; drop_seen = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        test_overflow_and_stale();
        test_random();
        drain_and_settle();
        if (expected_words.size() != 0) errors++;
        $display("covered %0d edge words and %0d runs, %0d vertex words checked",
                 edges_sent, runs_sent, words_seen);
        $display("vertex counts 0 to 31, overflow, stale and dropped edges exercised");
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule

// ----- strongly_connected_components.f -----
src/scc_pkg.sv
src/scc_datapath.sv
src/scc_ctrl.sv
src/strongly_connected_components.sv
test/tb_top.sv
